[hw/rtl/spf_pkg.sv]
// Types, constants and the divider step shared by the sweep point frequency block.
package spf_pkg;

    localparam int TRK_W = 5;
    localparam int PTS_W = 11;
    localparam int CFG_W = 11;
    localparam int DEN_W = 16;
    localparam int QUO_W = 29;
    localparam int NUM_W = QUO_W + DEN_W;
    localparam int FRQ_W = 30;
    localparam int WIN_W = 2;

    localparam logic [TRK_W-1:0] TRACK_COUNT_RST = 5'd4;
    localparam logic [PTS_W-1:0] POINTS_RST = 11'd64;

    localparam logic REG_TRACK_COUNT = 1'b0;
    localparam logic REG_POINTS_PER_TRACK = 1'b1;

    localparam logic [WIN_W-1:0] WIN_LOW = 2'd0;
    localparam logic [WIN_W-1:0] WIN_MID = 2'd1;
    localparam logic [WIN_W-1:0] WIN_HIGH = 2'd2;
    localparam logic [WIN_W-1:0] WIN_NONE = 2'd3;

    localparam logic [QUO_W-1:0] SPAN_HZ = 29'd274000000;
    localparam logic [FRQ_W-1:0] W0_SPAN = 30'd48000000;
    localparam logic [FRQ_W-1:0] W1_END_OFF = 30'd125000000;
    localparam logic [FRQ_W-1:0] W0_LO = 30'd300000000;
    localparam logic [FRQ_W-1:0] W0_HI = 30'd348000000;
    localparam logic [FRQ_W-1:0] W1_LO = 30'd387000000;
    localparam logic [FRQ_W-1:0] W1_HI = 30'd464000000;
    localparam logic [FRQ_W-1:0] W2_LO = 30'd779000000;
    localparam logic [FRQ_W-1:0] W2_HI = 30'd928000000;
    localparam logic [FRQ_W-1:0] W1_BASE = W1_LO - W0_SPAN;
    localparam logic [FRQ_W-1:0] W2_BASE = W2_LO - W1_END_OFF;

    typedef struct packed {
        logic vld;
        logic ok;
    } t_ctl;

    typedef struct packed {
        logic             qbit;
        logic [DEN_W-1:0] rem;
    } t_step;

    // One restoring division step: bring in the next dividend bit, subtract if it fits.
    function automatic t_step div_step(input logic [DEN_W-1:0] rem, input logic nb,
                                       input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        t_step          s;
        t = {rem, nb};
        d = {1'b0, den};
        s.qbit = (t >= d);
        s.rem = s.qbit ? DEN_W'(t - d) : t[DEN_W-1:0];
        return s;
    endfunction

endpackage

[hw/rtl/sweep_point_frequency.sv]
// Sweep point frequency: maps a track and sweep point to a receive frequency.
// Pipeline: a word accepted with start is on the outputs with o_strobe after its registered
// stages: range check and index, scaling multiply, 29 divider stages, window map.
// Throughput: one word per cycle; busy stays low, set by the fully pipelined divider.
// Reset: synchronous active-low i_rst_n clears all stage valid bits and o_strobe
// and loads track_count 4 and points_per_track 64; words in flight are dropped.
module sweep_point_frequency #(
    parameter int MIN_TRACKS = 1,
    parameter int MAX_TRACKS = 16,
    parameter int MIN_POINTS = 2,
    parameter int MAX_POINTS = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [spf_pkg::TRK_W-1:0] i_track_index,
    input  logic [spf_pkg::PTS_W-1:0] i_point_index,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [spf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_strobe,
    output logic [spf_pkg::FRQ_W-1:0] o_frequency_hz,
    output logic                      o_valid_res,
    output logic [spf_pkg::WIN_W-1:0] o_window_index
);

    localparam logic [spf_pkg::TRK_W-1:0] MIN_TRK = spf_pkg::TRK_W'(MIN_TRACKS);
    localparam logic [spf_pkg::TRK_W-1:0] MAX_TRK = spf_pkg::TRK_W'(MAX_TRACKS);
    localparam logic [spf_pkg::PTS_W-1:0] MIN_PTS = spf_pkg::PTS_W'(MIN_POINTS);
    localparam logic [spf_pkg::PTS_W-1:0] MAX_PTS = spf_pkg::PTS_W'(MAX_POINTS);
    localparam int LATENCY = spf_pkg::QUO_W + 3;

    logic [spf_pkg::TRK_W-1:0] r_track_count;
    logic [spf_pkg::PTS_W-1:0] r_points;

    logic [spf_pkg::PTS_W-1:0] segs;
    logic                      n_s1_ok;
    logic [spf_pkg::DEN_W:0]   idx_sum;
    logic [spf_pkg::DEN_W-1:0] n_s1_den;

    spf_pkg::t_ctl             r_s1_ctl;
    logic [spf_pkg::DEN_W-1:0] r_s1_idx;
    logic [spf_pkg::DEN_W-1:0] r_s1_den;

    spf_pkg::t_ctl             r_s2_ctl;
    logic [spf_pkg::NUM_W-1:0] r_s2_num;
    logic [spf_pkg::DEN_W-1:0] r_s2_den;

    spf_pkg::t_ctl             div_ctl;
    logic [spf_pkg::QUO_W-1:0] div_quo;
    logic [spf_pkg::FRQ_W-1:0] offset;

    logic                      r_out_stb;
    logic [spf_pkg::FRQ_W-1:0] r_out_freq;
    logic                      r_out_ok;
    logic [spf_pkg::WIN_W-1:0] r_out_win;
    logic [spf_pkg::FRQ_W-1:0] n_out_freq;
    logic [spf_pkg::WIN_W-1:0] n_out_win;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= spf_pkg::TRACK_COUNT_RST;
            r_points      <= spf_pkg::POINTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spf_pkg::REG_TRACK_COUNT: begin
                    r_track_count <= i_cfg_data[spf_pkg::TRK_W-1:0];
                end
                spf_pkg::REG_POINTS_PER_TRACK: begin
                    r_points <= i_cfg_data[spf_pkg::PTS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign segs = r_points - spf_pkg::PTS_W'(1);

    always_comb begin
        n_s1_ok = (r_track_count >= MIN_TRK) && (r_track_count <= MAX_TRK) &&
                  (r_points >= MIN_PTS) && (r_points <= MAX_PTS) &&
                  (i_track_index < r_track_count) && (i_point_index < r_points) &&
                  (segs != '0);
        idx_sum  = (spf_pkg::DEN_W+1)'(i_track_index * segs) +
                   (spf_pkg::DEN_W+1)'(i_point_index);
        n_s1_den = spf_pkg::DEN_W'(r_track_count * segs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
        end else begin
            r_s1_ctl.vld <= start && !busy;
            r_s1_ctl.ok  <= n_s1_ok;
            r_s2_ctl     <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= idx_sum[spf_pkg::DEN_W-1:0];
        r_s1_den <= n_s1_den;
        r_s2_num <= spf_pkg::NUM_W'(spf_pkg::SPAN_HZ * r_s1_idx);
        r_s2_den <= r_s1_den;
    end

    spf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_s2_ctl),
        .i_num  (r_s2_num),
        .i_den  (r_s2_den),
        .o_ctl  (div_ctl),
        .o_quo  (div_quo)
    );

    assign offset = spf_pkg::FRQ_W'(div_quo);

    always_comb begin
        n_out_freq = '0;
        n_out_win  = spf_pkg::WIN_NONE;
        if (div_ctl.ok) begin
            if (offset <= spf_pkg::W0_SPAN) begin
                n_out_freq = spf_pkg::W0_LO + offset;
                n_out_win  = spf_pkg::WIN_LOW;
            end else if (offset <= spf_pkg::W1_END_OFF) begin
                n_out_freq = spf_pkg::W1_BASE + offset;
                n_out_win  = spf_pkg::WIN_MID;
            end else begin
                n_out_freq = spf_pkg::W2_BASE + offset;
                n_out_win  = spf_pkg::WIN_HIGH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_stb <= 1'b0;
        end else begin
            r_out_stb <= div_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_freq <= n_out_freq;
        r_out_ok   <= div_ctl.ok;
        r_out_win  <= n_out_win;
    end

    assign o_strobe       = r_out_stb;
    assign o_frequency_hz = r_out_freq;
    assign o_valid_res    = r_out_ok;
    assign o_window_index = r_out_win;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted word did not reach the output on time");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |->
            (o_frequency_hz == '0) && (o_window_index == spf_pkg::WIN_NONE))
        else $error("invalid word carries a frequency or window");

    a_valid_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res) |->
            (o_window_index != spf_pkg::WIN_NONE) &&
            (o_frequency_hz >= spf_pkg::W0_LO) && (o_frequency_hz <= spf_pkg::W2_HI))
        else $error("valid word outside the receive windows");

    a_window_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_window_index == spf_pkg::WIN_LOW)) |->
            (o_frequency_hz <= spf_pkg::W0_HI))
        else $error("low window frequency out of range");

    a_window_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_window_index == spf_pkg::WIN_MID)) |->
            (o_frequency_hz >= spf_pkg::W1_LO) && (o_frequency_hz <= spf_pkg::W1_HI))
        else $error("mid window frequency out of range");
`endif

endmodule

[hw/rtl/spf_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
module spf_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spf_pkg::t_ctl             i_ctl,
    input  logic [spf_pkg::NUM_W-1:0] i_num,
    input  logic [spf_pkg::DEN_W-1:0] i_den,
    output spf_pkg::t_ctl             o_ctl,
    output logic [spf_pkg::QUO_W-1:0] o_quo
);

    spf_pkg::t_ctl             r_ctl [spf_pkg::QUO_W];
    logic [spf_pkg::DEN_W-1:0] r_rem [spf_pkg::QUO_W];
    logic [spf_pkg::QUO_W-1:0] r_lo  [spf_pkg::QUO_W];
    logic [spf_pkg::DEN_W-1:0] r_den [spf_pkg::QUO_W];

    for (genvar k = 0; k < spf_pkg::QUO_W; k++) begin : g_stage
        spf_pkg::t_ctl             c_in;
        logic [spf_pkg::DEN_W-1:0] rem_in;
        logic [spf_pkg::QUO_W-1:0] lo_in;
        logic [spf_pkg::DEN_W-1:0] den_in;
        spf_pkg::t_step            step;

        if (k == 0) begin : g_first
            assign c_in   = i_ctl;
            assign rem_in = i_num[spf_pkg::NUM_W-1 -: spf_pkg::DEN_W];
            assign lo_in  = i_num[spf_pkg::QUO_W-1:0];
            assign den_in = i_den;
        end else begin : g_next
            assign c_in   = r_ctl[k-1];
            assign rem_in = r_rem[k-1];
            assign lo_in  = r_lo[k-1];
            assign den_in = r_den[k-1];
        end

        assign step = spf_pkg::div_step(rem_in, lo_in[spf_pkg::QUO_W-1], den_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= c_in;
            end
        end

        // Shift dividend bits out and quotient bits in through the same register.
        always_ff @(posedge i_clk) begin
            r_rem[k] <= step.rem;
            r_lo[k]  <= {lo_in[spf_pkg::QUO_W-2:0], step.qbit};
            r_den[k] <= den_in;
        end
    end

    assign o_ctl = r_ctl[spf_pkg::QUO_W-1];
    assign o_quo = r_lo[spf_pkg::QUO_W-1];

endmodule
